/* hdl/apnd_pkg.sv */
// Shared types, constants and helper functions for the autocorrelation pitch detector.
// No dependencies; every other file of the block uses this package.
package apnd_pkg;

    // Default sizes handed down from the top level
    localparam int MAX_WINDOW_DEF  = 2048;
    localparam int SAMPLE_BITS_DEF = 18;

    // Register and field widths
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 47;
    localparam int WLOG_BITS     = 4;
    localparam int HOP_BITS      = 12;
    localparam int FRAC_BITS     = 16;
    localparam int NOISE_BITS    = 47;
    localparam int RATE_BITS     = 18;
    localparam int NOTE_BITS     = 7;
    localparam int PERIOD_BITS   = 11;

    // Log2 unit: input width and Q16 result width (5 integer bits)
    localparam int LOG_IN_BITS = 18;
    localparam int LOG_E_BITS  = 5;
    localparam int LOG_F_BITS  = 16;
    localparam int LOG_Q_BITS  = LOG_E_BITS + LOG_F_BITS;

    // Algorithm constants
    localparam int MIN_WINDOW_LOG2 = 5;
    localparam int REF_PITCH_HZ    = 440;
    localparam int REF_NOTE        = 69;
    localparam int TOP_NOTE        = 127;
    localparam int RANGE_LIMIT     = 32768;
    localparam int NOTE_SEMITONES  = 12;

    // Register reset values
    localparam int RST_WINDOW_LOG2 = 11;
    localparam int RST_HOP_SIZE    = 512;
    localparam int RST_CORR_FRAC   = 32768;
    localparam int RST_SAMPLE_RATE = 48000;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LOG2    = 3'd0,
        CFG_HOP_SIZE       = 3'd1,
        CFG_CORR_FRACTION  = 3'd2,
        CFG_NOISE_FLOOR    = 3'd3,
        CFG_SAMPLE_RATE_HZ = 3'd4,
        CFG_RANGE_CHECK_ON = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [WLOG_BITS-1:0]  window_log2;
        logic [HOP_BITS-1:0]   hop_size;
        logic [FRAC_BITS-1:0]  corr_fraction;
        logic [NOISE_BITS-1:0] noise_floor;
        logic [RATE_BITS-1:0]  sample_rate_hz;
        logic                  range_check_on;
    } cfg_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EVAL,
        ST_THR1,
        ST_THR2,
        ST_LOGF_GO,
        ST_LOGF_WAIT,
        ST_LOGT_GO,
        ST_LOGT_WAIT,
        ST_NOTE,
        ST_PUT,
        ST_HOP
    } ctrl_state_t;

    // Log2 unit phases
    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_SQUARE
    } log_phase_t;

    // Controller to datapath commands
    typedef struct packed {
        logic store;
        logic start;
        logic issue;
        logic eval;
        logic thr1;
        logic thr2;
        logic log_start;
        logic log_sel_t;
        logic save_lf;
        logic note_calc;
        logic out_load;
        logic hop;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fill_done;
        logic last_issue;
        logic k_zero;
        logic k_last;
        logic peak_now;
        logic no_note;
        logic log_done;
        logic out_free;
    } status_t;

    // Q16 log2 of a constant, same rounds as the hardware unit
    function automatic logic [LOG_Q_BITS-1:0] log2_q16_const(input logic [31:0] v);
        logic [LOG_E_BITS-1:0] e;
        logic [63:0]           m;
        logic [LOG_F_BITS-1:0] f;
        e = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) e = LOG_E_BITS'(i);
        end
        m = 64'(v) << (30 - int'(e));
        f = '0;
        for (int i = 0; i < LOG_F_BITS; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'h0000_0000_8000_0000) begin
                m = m >> 1;
                f[LOG_F_BITS-1-i] = 1'b1;
            end
        end
        return {e, f};
    endfunction

    localparam logic [LOG_Q_BITS-1:0] LOG2_REF_PITCH = log2_q16_const(32'(REF_PITCH_HZ));

endpackage

/* hdl/apnd_sample_if.sv */
// Input channel interface: one audio sample per beat.
// Depends on apnd_pkg for the default sample width.
interface apnd_sample_if #(
    parameter int SAMPLE_BITS = apnd_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/apnd_note_if.sv */
// Result channel interface: one detected note per beat.
// Depends on apnd_pkg for field widths.
interface apnd_note_if;
    logic                               valid;
    logic                               ready;
    logic [apnd_pkg::NOTE_BITS-1:0]     note;
    logic                               note_valid;
    logic [apnd_pkg::PERIOD_BITS-1:0]   period_lag;

    modport source (output valid, output note, output note_valid, output period_lag,
                    input ready);
    modport sink   (input valid, input note, input note_valid, input period_lag,
                    output ready);
endinterface

/* hdl/apnd_cfg_if.sv */
// Configuration write channel interface: register index and write data per beat.
// Depends on apnd_pkg for field widths.
interface apnd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [apnd_pkg::CFG_IDX_BITS-1:0]   index;
    logic [apnd_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/apnd_log2.sv */
// Iterative Q16 log2 unit: normalizing shift one bit a cycle, then 16 squaring rounds.
// Depends on apnd_pkg; used by apnd_dp.
module apnd_log2 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [apnd_pkg::LOG_IN_BITS-1:0] value,
    output logic                             done,
    output logic [apnd_pkg::LOG_Q_BITS-1:0]  result
);
    import apnd_pkg::*;

    localparam int MW = 31;

    log_phase_t             phase_reg, phase_next;
    logic [MW-1:0]          x_reg;
    logic [LOG_E_BITS-1:0]  e_reg;
    logic [LOG_F_BITS-1:0]  frac_reg;
    logic [3:0]             round_reg;
    logic                   done_reg;
    logic [2*MW-1:0]        sq;
    logic [MW:0]            sq_top;

    // Square the Q30 mantissa and keep the Q30 part
    assign sq     = (2*MW)'(x_reg) * (2*MW)'(x_reg);
    assign sq_top = sq[2*MW-1:MW-1];

    // Phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            LOG_IDLE:   if (start) phase_next = LOG_NORM;
            LOG_NORM:   if (x_reg[MW-1]) phase_next = LOG_SQUARE;
            LOG_SQUARE: if (round_reg == 4'(LOG_F_BITS - 1)) phase_next = LOG_IDLE;
            default:    phase_next = LOG_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LOG_IDLE;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == LOG_SQUARE) && (round_reg == 4'(LOG_F_BITS - 1));
            if (phase_reg == LOG_SQUARE)
                round_reg <= round_reg + 4'd1;
            else
                round_reg <= '0;
        end
    end

    // Mantissa, exponent and fraction bits
    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            LOG_IDLE:
            begin
                if (start)
                begin
                    x_reg <= MW'(value);
                    e_reg <= LOG_E_BITS'(MW - 1);
                end
            end
            LOG_NORM:
            begin
                if (!x_reg[MW-1])
                begin
                    x_reg <= {x_reg[MW-2:0], 1'b0};
                    e_reg <= e_reg - 1'b1;
                end
                frac_reg <= '0;
            end
            LOG_SQUARE:
            begin
                x_reg    <= sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
                frac_reg <= {frac_reg[LOG_F_BITS-2:0], sq_top[MW]};
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

endmodule

/* hdl/apnd_ctrl.sv */
// Controller state machine: sequences sample intake, lag sums, threshold, log2 and output.
// Depends on apnd_pkg; drives apnd_dp through cmd_t and reads status_t.
module apnd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  apnd_pkg::status_t status,
    output apnd_pkg::cmd_t    cmd
);
    import apnd_pkg::*;

    ctrl_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid && status.fill_done) state_next = ST_ISSUE;
            ST_ISSUE:     if (status.last_issue) state_next = ST_DRAIN1;
            ST_DRAIN1:    state_next = ST_DRAIN2;
            ST_DRAIN2:    state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (status.k_zero)
                    state_next = ST_THR1;
                else if (status.peak_now || status.k_last)
                    state_next = status.no_note ? ST_NOTE : ST_LOGF_GO;
                else
                    state_next = ST_ISSUE;
            end
            ST_THR1:      state_next = ST_THR2;
            ST_THR2:      state_next = ST_ISSUE;
            ST_LOGF_GO:   state_next = ST_LOGF_WAIT;
            ST_LOGF_WAIT: if (status.log_done) state_next = ST_LOGT_GO;
            ST_LOGT_GO:   state_next = ST_LOGT_WAIT;
            ST_LOGT_WAIT: if (status.log_done) state_next = ST_NOTE;
            ST_NOTE:      state_next = ST_PUT;
            ST_PUT:       if (status.out_free) state_next = ST_HOP;
            ST_HOP:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd           = '0;
        in_ready      = (state_reg == ST_IDLE);
        cmd.store     = (state_reg == ST_IDLE) && in_valid;
        cmd.start     = (state_reg == ST_IDLE) && in_valid && status.fill_done;
        cmd.issue     = (state_reg == ST_ISSUE);
        cmd.eval      = (state_reg == ST_EVAL);
        cmd.thr1      = (state_reg == ST_THR1);
        cmd.thr2      = (state_reg == ST_THR2);
        cmd.log_start = (state_reg == ST_LOGF_GO) || (state_reg == ST_LOGT_GO);
        cmd.log_sel_t = (state_reg == ST_LOGT_GO);
        cmd.save_lf   = (state_reg == ST_LOGF_WAIT) && status.log_done;
        cmd.note_calc = (state_reg == ST_NOTE);
        cmd.out_load  = (state_reg == ST_PUT) && status.out_free;
        cmd.hop       = (state_reg == ST_HOP);
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef NO_ASSERTIONS
    // The log path is only taken when a note is possible
    a_log_needs_note: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOGF_WAIT |-> !status.no_note)
        else $error("log2 run while no note is possible");

    // The last element of a lag reaches evaluation after the pipeline drains
    a_drain_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) && status.last_issue |=> ##2 state_reg == ST_EVAL)
        else $error("lag evaluation not reached after drain");

    // A new analysis starts at lag zero
    a_start_lag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_ISSUE) && status.k_zero)
        else $error("analysis did not start at lag zero");
`endif

endmodule

/* hdl/apnd_dp.sv */
// Datapath: window memory, lag multiply-accumulate pipeline, peak search, threshold,
// note arithmetic and result register. Depends on apnd_pkg and apnd_log2.
module apnd_dp #(
    parameter int MAX_WINDOW  = apnd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = apnd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  apnd_pkg::cfg_t                    cfg,
    input  apnd_pkg::cmd_t                    cmd,
    output apnd_pkg::status_t                 status,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [apnd_pkg::NOTE_BITS-1:0]    note,
    output logic                              note_valid,
    output logic [apnd_pkg::PERIOD_BITS-1:0]  period_lag
);
    import apnd_pkg::*;

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int CW   = AW + 1;
    localparam int PW   = 2 * SAMPLE_BITS;
    localparam int ACCW = PW + AW;
    localparam int CMPW = (SAMPLE_BITS > 17) ? SAMPLE_BITS + 1 : 18;
    localparam int NCW  = (ACCW > NOISE_BITS) ? ACCW : NOISE_BITS;
    localparam int HW   = (CW > HOP_BITS) ? CW : HOP_BITS;
    localparam int LDW  = LOG_Q_BITS + 2;
    localparam int SW   = LDW + 4;
    localparam int NSW  = 12;

    localparam logic signed [CMPW-1:0] LIM_P = CMPW'(RANGE_LIMIT);
    localparam logic signed [CMPW-1:0] LIM_N = -LIM_P;

    // Window memory and read data
    logic signed [SAMPLE_BITS-1:0] win_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_a_reg, rd_b_reg;

    // Window bookkeeping
    logic [WLOG_BITS-1:0] wexp;
    logic [CW-1:0]        win_len;
    logic [HW-1:0]        hop_ext;
    logic [CW-1:0]        hop_len;
    logic [CW-1:0]        fill_reg, fill_c, fill_inc;
    logic [AW-1:0]        base_reg;
    logic [AW-1:0]        wr_addr, addr_a, addr_b;

    // Lag loop
    logic [CW-1:0]           k_reg, n_reg, period_reg;
    logic                    v1_reg, v2_reg, stop_reg, peak_reg;
    logic                    over_a, over_b, over_hit;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ACCW-1:0]  acc_reg, prev_reg;
    logic [ACCW-1:0]         s0_reg, thr_hi_reg, thres_reg;
    logic [FRAC_BITS-1:0]    thr_lo_reg;
    logic signed [ACCW:0]    acc_x, thr_x;
    logic                    acc_gt_prev, peak_now;

    // Note arithmetic
    logic [LOG_IN_BITS-1:0]  log_value;
    logic                    log_done;
    logic [LOG_Q_BITS-1:0]   log_res, lf_reg;
    logic signed [LDW-1:0]   l_diff;
    logic signed [SW-1:0]    s_val;
    logic [SW-1:0]           s_abs, r_mag;
    logic signed [NSW-1:0]   note_s;
    logic                    in_range, no_note;
    logic [NOTE_BITS-1:0]    note_res_reg;
    logic                    valid_res_reg;

    // Output register
    logic                    out_valid_reg;
    logic [NOTE_BITS-1:0]    note_reg;
    logic                    note_valid_reg;
    logic [PERIOD_BITS-1:0]  period_out_reg;

    // Window length from the exponent, floored and capped
    always_comb
    begin
        wexp = cfg.window_log2;
        if (wexp < WLOG_BITS'(MIN_WINDOW_LOG2))
            wexp = WLOG_BITS'(MIN_WINDOW_LOG2);
        if (int'(wexp) >= AW)
            win_len = CW'(MAX_WINDOW);
        else
            win_len = CW'(1) << wexp;
    end

    // Hop clamped to 1..window
    always_comb
    begin
        hop_ext = HW'(cfg.hop_size);
        if (hop_ext == '0)
            hop_ext = HW'(1);
        if (hop_ext > HW'(win_len))
            hop_ext = HW'(win_len);
        hop_len = CW'(hop_ext);
    end

    // Fill count, cut back if the window shrank
    assign fill_c   = (fill_reg >= win_len) ? win_len - 1'b1 : fill_reg;
    assign fill_inc = fill_c + 1'b1;
    assign wr_addr  = base_reg + fill_c[AW-1:0];
    assign addr_a   = base_reg + n_reg[AW-1:0];
    assign addr_b   = addr_a + k_reg[AW-1:0];

    // Window memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            win_mem[wr_addr] <= sample;
        if (cmd.issue)
        begin
            rd_a_reg <= win_mem[addr_a];
            rd_b_reg <= win_mem[addr_b];
        end
    end

    // Range test on the read pair
    assign over_a   = (CMPW'(rd_a_reg) > LIM_P) || (CMPW'(rd_a_reg) < LIM_N);
    assign over_b   = (CMPW'(rd_b_reg) > LIM_P) || (CMPW'(rd_b_reg) < LIM_N);
    assign over_hit = cfg.range_check_on && (over_a || over_b);

    // Peak comparisons
    assign acc_gt_prev = acc_reg > prev_reg;
    assign acc_x       = (ACCW+1)'(acc_reg);
    assign thr_x       = signed'({1'b0, thres_reg});
    assign peak_now    = (k_reg != '0) && peak_reg && !acc_gt_prev;
    assign no_note     = (NCW'(thres_reg) <= NCW'(cfg.noise_floor))
                         || (cfg.sample_rate_hz == '0);

    // Window pointers and lag counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            base_reg   <= '0;
            k_reg      <= '0;
            n_reg      <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            stop_reg   <= 1'b0;
            peak_reg   <= 1'b0;
            period_reg <= CW'(1);
            acc_reg    <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg && !stop_reg && !over_hit;
            if (cmd.store)
                fill_reg <= fill_inc;
            else if (cmd.hop)
            begin
                fill_reg <= fill_reg - hop_len;
                base_reg <= base_reg + hop_len[AW-1:0];
            end
            if (cmd.start)
            begin
                k_reg      <= '0;
                n_reg      <= '0;
                peak_reg   <= 1'b0;
                period_reg <= CW'(1);
                acc_reg    <= '0;
                stop_reg   <= 1'b0;
            end
            else if (cmd.eval)
            begin
                k_reg    <= k_reg + 1'b1;
                n_reg    <= '0;
                acc_reg  <= '0;
                stop_reg <= 1'b0;
                if (peak_now)
                    period_reg <= k_reg - 1'b1;
                else if ((k_reg != '0) && acc_gt_prev && (acc_x > thr_x))
                    peak_reg <= 1'b1;
            end
            else
            begin
                if (cmd.issue)
                    n_reg <= n_reg + 1'b1;
                if (v1_reg && over_hit)
                    stop_reg <= 1'b1;
                if (v2_reg)
                    acc_reg <= acc_reg + ACCW'(prod_reg);
            end
        end
    end

    // Product, previous sum, threshold and log registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(rd_a_reg) * PW'(rd_b_reg);
        if (cmd.eval)
        begin
            prev_reg <= acc_reg;
            if (k_reg == '0)
                s0_reg <= ACCW'(acc_reg);
        end
        if (cmd.thr1)
        begin
            thr_hi_reg <= ACCW'(s0_reg[ACCW-1:FRAC_BITS]) * ACCW'(cfg.corr_fraction);
            thr_lo_reg <= FRAC_BITS'((32'(s0_reg[FRAC_BITS-1:0])
                                      * 32'(cfg.corr_fraction)) >> FRAC_BITS);
        end
        if (cmd.thr2)
            thres_reg <= thr_hi_reg + ACCW'(thr_lo_reg);
        if (cmd.save_lf)
            lf_reg <= log_res;
    end

    // Shared log2 unit
    assign log_value = cmd.log_sel_t ? LOG_IN_BITS'(period_reg)
                                     : LOG_IN_BITS'(cfg.sample_rate_hz);

    apnd_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_start),
        .value  (log_value),
        .done   (log_done),
        .result (log_res)
    );

    // Note = 69 + round(12 * (log2 fs - log2 T - log2 440)), ties away from zero
    always_comb
    begin
        l_diff   = signed'(LDW'(lf_reg)) - signed'(LDW'(log_res))
                   - signed'(LDW'(LOG2_REF_PITCH));
        s_val    = SW'(l_diff) * SW'(NOTE_SEMITONES);
        s_abs    = s_val[SW-1] ? SW'(-s_val) : SW'(s_val);
        r_mag    = (s_abs + SW'(RANGE_LIMIT)) >> LOG_F_BITS;
        note_s   = s_val[SW-1] ? NSW'(REF_NOTE) - signed'(NSW'(r_mag))
                               : NSW'(REF_NOTE) + signed'(NSW'(r_mag));
        in_range = !note_s[NSW-1] && (note_s <= NSW'(TOP_NOTE));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.note_calc)
        begin
            valid_res_reg <= !no_note && in_range;
            note_res_reg  <= (!no_note && in_range) ? note_s[NOTE_BITS-1:0] : '0;
        end
        if (cmd.out_load)
        begin
            note_reg       <= note_res_reg;
            note_valid_reg <= valid_res_reg;
            period_out_reg <= PERIOD_BITS'(period_reg);
        end
    end

    // Result beat: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign note       = note_reg;
    assign note_valid = note_valid_reg;
    assign period_lag = period_out_reg;

    always_comb
    begin
        status            = '0;
        status.fill_done  = (fill_inc == win_len);
        status.last_issue = (n_reg == win_len - k_reg - 1'b1);
        status.k_zero     = (k_reg == '0);
        status.k_last     = (k_reg == win_len - 1'b1);
        status.peak_now   = peak_now;
        status.no_note    = no_note;
        status.log_done   = log_done;
        status.out_free   = !out_valid_reg || out_ready;
    end

`ifndef NO_ASSERTIONS
    // The accumulator only moves on a product or a lag boundary
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !v2_reg && !cmd.start && !cmd.eval |=> $stable(acc_reg))
        else $error("accumulator changed without a product");

    // A product reaches the accumulator only behind a read
    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("product stage valid without read stage");

    // The fill count never passes the memory depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_WINDOW))
        else $error("fill count beyond window memory");

    // A reported period is never zero
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> period_reg != '0)
        else $error("zero period loaded into result");
`endif

endmodule

/* hdl/autocorrelation_pitch_note_detector_top.sv */
// Top level of the autocorrelation pitch detector: configuration registers,
// controller and datapath. Depends on apnd_pkg, the channel interfaces, apnd_ctrl, apnd_dp.
//
// Usage:
//   samples : one signed Q3.14 sample per beat, taken while the block is collecting;
//             a window of W = 2^window_log2 samples (at least 32, capped at
//             MAX_WINDOW) starts an analysis when the last sample lands.
//   notes   : one result beat per analysis (note, note_valid, period_lag).
//   cfg     : register writes, always ready; write only while the block is idle.
// Analysis: an analysis runs lag by lag through one multiply-accumulate pipeline
//   fed by the two read ports of the window memory. Lag k issues W - k read pairs,
//   then passes two drain stages and an evaluate state; lag zero adds the threshold
//   states THR1 and THR2. The search stops at the first peak or at the last lag;
//   then the iterative log2 unit runs twice (sample rate, then period) unless no
//   note is possible, and the note is computed and loaded into the output register.
// Throughput: hop_size samples are taken per analysis, so the cost of an analysis
//   is spread over hop_size input beats.
// Reset: the window is empty, registers take their defaults, no result pending.
// Stall: a finished result waits in the output register; new samples are still
//   taken, and a later analysis waits only if that register is still full.
module autocorrelation_pitch_note_detector_top #(
    parameter int MAX_WINDOW  = apnd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = apnd_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    apnd_sample_if.sink   samples,
    apnd_note_if.source   notes,
    apnd_cfg_if.sink      cfg
);
    import apnd_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_WINDOW_LOG2:    cfg_next.window_log2    = cfg.data[WLOG_BITS-1:0];
                CFG_HOP_SIZE:       cfg_next.hop_size       = cfg.data[HOP_BITS-1:0];
                CFG_CORR_FRACTION:  cfg_next.corr_fraction  = cfg.data[FRAC_BITS-1:0];
                CFG_NOISE_FLOOR:    cfg_next.noise_floor    = cfg.data[NOISE_BITS-1:0];
                CFG_SAMPLE_RATE_HZ: cfg_next.sample_rate_hz = cfg.data[RATE_BITS-1:0];
                CFG_RANGE_CHECK_ON: cfg_next.range_check_on = cfg.data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_log2    <= WLOG_BITS'(RST_WINDOW_LOG2);
            cfg_reg.hop_size       <= HOP_BITS'(RST_HOP_SIZE);
            cfg_reg.corr_fraction  <= FRAC_BITS'(RST_CORR_FRAC);
            cfg_reg.noise_floor    <= '0;
            cfg_reg.sample_rate_hz <= RATE_BITS'(RST_SAMPLE_RATE);
            cfg_reg.range_check_on <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg.ready     = 1'b1;
    assign samples.ready = in_ready;

    apnd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    apnd_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .sample     (SAMPLE_BITS'(samples.sample)),
        .out_ready  (notes.ready),
        .out_valid  (notes.valid),
        .note       (notes.note),
        .note_valid (notes.note_valid),
        .period_lag (notes.period_lag)
    );

endmodule
